// ===== rtl/lapk_pkg.sv =====
// shared types, constants and exp table function for the laplacian kernel block
package lapk_pkg;

  localparam int SUM_WIDTH       = 26;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int DECAY_W = 16;
  localparam int ELEM_W  = 16;
  localparam int MAG_W   = 16;
  localparam int VAL_W   = 16;
  localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
  localparam int KBITS   = 4;
  localparam int LN2_W   = 20;
  localparam int PROD_W  = DECAY_W + SUM_WIDTH;
  // below 16*ln2 the product fits in red_w bits
  localparam int RED_W   = LN2_W + KBITS;
  localparam int K_SHIFT = RED_W + LN2_W;
  localparam int I_SHIFT = 2 * LN2_W;
  localparam int KP_W    = 2 * RED_W + 1;
  localparam int IP_W    = 2 * LN2_W + IDX_W + 1;

  localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(4096);
  localparam logic [LN2_W-1:0]   LN2_Q20     = LN2_W'(726817);
  localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
  // products at or above 16*ln2 shift the result out entirely
  localparam logic [PROD_W-1:0]  UFLOW_LIM   = PROD_W'(64'(LN2_Q20) * 64'd16);

  // reciprocals of ln2 rounded up, the high product bits give the exact floor quotient
  localparam logic [RED_W:0]       K_RECIP = (RED_W+1)'(
    ((64'd1 << K_SHIFT) + 64'(LN2_Q20) - 64'd1) / 64'(LN2_Q20));
  localparam logic [LN2_W+IDX_W:0] I_RECIP = (LN2_W+IDX_W+1)'(
    ((64'(EXP_TABLE_DEPTH) << I_SHIFT) + 64'(LN2_Q20) - 64'd1) / 64'(LN2_Q20));

  typedef struct packed {
    logic signed [ELEM_W-1:0] first_element;
    logic signed [ELEM_W-1:0] second_element;
    logic                     final_pair;
  } lapk_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] kernel_value;
    logic             sum_saturated;
  } lapk_out_t;

  typedef struct packed {
    logic             acc_en;
    logic             job_load;
    logic             mul_en;
    logic             load_en;
    logic             kstep_en;
    logic             scale_en;
    logic             istep_en;
    logic             out_load;
  } lapk_cmd_t;

  typedef struct packed {
    logic uflow;
  } lapk_stat_t;

  // 2^(-i/depth) in Q1.15 by a truncating Q.32 taylor series, evaluated at elaboration
  function automatic logic [VAL_W-1:0] pow2_entry(input int unsigned i);
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] acc;
    t    = (64'(i) * 64'(LN2_Q32)) / 64'(EXP_TABLE_DEPTH);
    term = 64'd1 << 32;
    acc  = 64'd1 << 32;
    for (int unsigned n = 1; n <= 24; n++) begin
      term = ((term * t) >> 32) / 64'(n);
      if (n[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return VAL_W'((acc + (64'd1 << 16)) >> 17);
  endfunction

endpackage

// ===== rtl/lapk_ctrl.sv =====
// controller for accumulation handoff, exp sequencing and the output register
module lapk_ctrl import lapk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_final_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  lapk_stat_t stat_i,
  output lapk_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_KDIV,
    S_SCALE,
    S_IDIV,
    S_OUT
  } state_e;

  state_e           state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;

  // only a final pair has to wait for the exp sequence
  assign in_stall_o = in_final_i && (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.acc_en   = accept;
    cmd_o.job_load = accept && in_final_i;
    case (state_q)
      S_IDLE: begin
        if (accept && in_final_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_en = 1'b1;
        state_d       = stat_i.uflow ? S_OUT : S_KDIV;
      end
      S_KDIV: begin
        cmd_o.kstep_en = 1'b1;
        state_d        = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale_en = 1'b1;
        state_d        = S_IDIV;
      end
      S_IDIV: begin
        cmd_o.istep_en = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/lapk_dp.sv =====
// datapath: l1 accumulator, decay multiply, ln2 range reduction, exp table
module lapk_dp import lapk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DECAY_W-1:0] cfg_wdata_i,
  input  lapk_in_t           in_word_i,
  input  lapk_cmd_t          cmd_i,
  output lapk_stat_t         stat_o,
  output lapk_out_t          out_word_o
);

  logic [DECAY_W-1:0]   decay_q;
  logic [SUM_WIDTH-1:0] acc_q;
  logic                 ovf_q;
  logic [SUM_WIDTH-1:0] job_sum_q;
  logic                 job_ovf_q;
  logic [PROD_W-1:0]    prod_q;
  logic [RED_W-1:0]     red_q;
  logic [LN2_W-1:0]     rem_q;
  logic [KBITS-1:0]     k_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 uflow_q;
  lapk_out_t            out_q;

  logic signed [ELEM_W:0] diff;
  logic [MAG_W-1:0]       mag;
  logic [SUM_WIDTH:0]     sum_ext;
  logic                   sum_ovf;
  logic [SUM_WIDTH-1:0]   sum_sat;
  logic [KP_W-1:0]        kprod;
  logic [RED_W-1:0]       rem_full;
  logic [IP_W-1:0]        iprod;
  logic [VAL_W-1:0]       exp_tbl [EXP_TABLE_DEPTH];
  logic [IDX_W-1:0]       tbl_idx;
  logic [VAL_W-1:0]       entry;
  logic [VAL_W:0]         rnd;
  logic [VAL_W:0]         rounded;
  logic [VAL_W-1:0]       kernel;

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tbl
    assign exp_tbl[g] = pow2_entry(g);
  end

  // |a-b| fits 16 bits unsigned
  assign diff    = (ELEM_W+1)'(in_word_i.first_element) - (ELEM_W+1)'(in_word_i.second_element);
  assign mag     = diff[ELEM_W] ? MAG_W'(-diff) : MAG_W'(diff);
  assign sum_ext = {1'b0, acc_q} + (SUM_WIDTH+1)'(mag);
  assign sum_ovf = sum_ext[SUM_WIDTH];
  assign sum_sat = sum_ovf ? '1 : sum_ext[SUM_WIDTH-1:0];

  assign stat_o.uflow = (prod_q >= UFLOW_LIM);

  // multiple of ln2 and table index by reciprocal multiplies, one step per cycle
  assign kprod    = KP_W'(red_q) * KP_W'(K_RECIP);
  assign rem_full = red_q - RED_W'(k_q) * RED_W'(LN2_Q20);
  assign iprod    = IP_W'(rem_q) * IP_W'(I_RECIP);

  assign tbl_idx = (32'(idx_q) > EXP_TABLE_DEPTH - 1) ? IDX_W'(EXP_TABLE_DEPTH - 1) : idx_q;
  assign entry   = exp_tbl[tbl_idx];
  assign rnd     = (k_q == '0) ? '0 : ((VAL_W+1)'(1) << (k_q - 1'b1));
  assign rounded = ({1'b0, entry} + rnd) >> k_q;
  assign kernel  = uflow_q ? '0 : rounded[VAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RESET;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        decay_q <= cfg_wdata_i;
      end
      if (cmd_i.acc_en) begin
        if (in_word_i.final_pair) begin
          acc_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          acc_q <= sum_sat;
          ovf_q <= ovf_q | sum_ovf;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.job_load) begin
      job_sum_q <= sum_sat;
      job_ovf_q <= ovf_q | sum_ovf;
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(decay_q) * PROD_W'(job_sum_q);
    end
    if (cmd_i.load_en) begin
      red_q   <= prod_q[RED_W-1:0];
      uflow_q <= stat_o.uflow;
    end
    if (cmd_i.kstep_en) begin
      k_q <= kprod[K_SHIFT +: KBITS];
    end
    if (cmd_i.scale_en) begin
      rem_q <= rem_full[LN2_W-1:0];
    end
    if (cmd_i.istep_en) begin
      idx_q <= iprod[I_SHIFT +: IDX_W];
    end
    if (cmd_i.out_load) begin
      out_q.kernel_value  <= kernel;
      out_q.sum_saturated <= job_ovf_q;
    end
  end

  assign out_word_o = out_q;

endmodule

// ===== rtl/laplacian_kernel_l1_exp.sv =====
// Laplacian kernel top level: streams element pairs of two vectors into a saturating
// L1 distance and returns exp(-decay_rate * distance) in Q1.15 once per vector.
// A pair is taken every cycle; only a final pair can stall. After the final pair the
// exp sequence steps through the multiply, a range check, the ln2 multiple, the
// remainder and the table index (both quotients by reciprocal multiplication), then
// table lookup and rounding shift into the output register once that is free; an
// underflowing product skips the ln2 multiple, remainder and index steps. A further
// final pair waits until the sequence is back to idle; a result stays in the output
// register until taken and does not block the accumulator.
module laplacian_kernel_l1_exp import lapk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DECAY_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lapk_in_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lapk_out_t          out_word_o
);

  lapk_cmd_t  cmd;
  lapk_stat_t stat;

  lapk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_final_i  (in_word_i.final_pair),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lapk_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/lapk_chk.sv =====
// port-level checker for the laplacian kernel block and its bind
module lapk_chk import lapk_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [DECAY_W-1:0] cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input lapk_in_t           in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lapk_out_t          out_word_o
);

  // a result word stays up until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  // the accumulator never backs up on a non-final pair
  a_no_stall_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_word_i.final_pair |-> !in_stall_o)
    else $error("non-final word stalled");

  // exp(-x) for x >= 0 never exceeds one
  a_kernel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.kernel_value <= VAL_W'(32768))
    else $error("kernel value above one");

  // no result follows directly on an accepted final word; the exp sequence comes between
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.final_pair && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind laplacian_kernel_l1_exp lapk_chk u_lapk_chk (.*);

// ===== tb/tb.sv =====
// testbench for the laplacian kernel block: directed words and random vector streams checked against a predictor
module tb import lapk_pkg::*; ();

  localparam longint unsigned LN2_FIX20  = 64'd726817;
  localparam longint unsigned LN2_FIX32  = 64'd2977044472;
  localparam int              HOLD_CYCLES = 400;
  localparam int              IDLE_LIMIT  = 5000;
  localparam int              SETTLE_CYCLES = 32;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [DECAY_W-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  lapk_in_t        in_word_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  lapk_out_t       out_word_o;

  laplacian_kernel_l1_exp u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // predictor state
  logic [VAL_W-1:0]     pow2_q15 [EXP_TABLE_DEPTH];
  logic [DECAY_W-1:0]   decay_q12 = DECAY_W'(4096);
  logic [SUM_WIDTH-1:0] dist_sum = '0;
  logic                 dist_sat = 1'b0;

  lapk_in_t  pair_queue [$];
  lapk_out_t kernel_due [$];
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned mismatches = 0;
  int unsigned hold_req = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // sender: bursts of random length with random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pair_queue.size() != 0) begin
        in_word_i  <= pair_queue.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that changes mode now and then, plus long hold-offs on request
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  int unsigned hold_seen;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      mode_left   <= 0;
      hold_left   <= 0;
      hold_seen   <= 0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(10, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= mode_left[1];
      endcase
    end
  end

  // monitor: predicts on every accepted word and checks every taken result
  always @(posedge clk_i) begin : monitor
    logic signed [ELEM_W:0] diff;
    logic [ELEM_W-1:0]      mag;
    logic [SUM_WIDTH:0]     grown;
    logic [63:0]            prod;
    logic [63:0]            k;
    logic [63:0]            r;
    logic [63:0]            idx;
    logic [63:0]            entry;
    lapk_out_t              want;
    lapk_in_t               pair;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (kernel_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: kernel_value %0d sum_saturated %0d",
                     out_word_o.kernel_value, out_word_o.sum_saturated);
          end
          mismatches++;
        end else begin
          want = kernel_due.pop_front();
          if (want.kernel_value !== out_word_o.kernel_value) begin
            if (mismatches < 10) begin
              $display("kernel_value mismatch: expected %0d got %0d",
                       want.kernel_value, out_word_o.kernel_value);
            end
            mismatches++;
          end
          if (want.sum_saturated !== out_word_o.sum_saturated) begin
            if (mismatches < 10) begin
              $display("sum_saturated mismatch: expected %0d got %0d",
                       want.sum_saturated, out_word_o.sum_saturated);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pair  = in_word_i;
        diff  = {pair.first_element[ELEM_W-1], pair.first_element}
              - {pair.second_element[ELEM_W-1], pair.second_element};
        mag   = diff[ELEM_W] ? ELEM_W'(-diff) : ELEM_W'(diff);
        grown = {1'b0, dist_sum} + (SUM_WIDTH+1)'(mag);
        if (grown[SUM_WIDTH]) begin
          dist_sum = '1;
          dist_sat = 1'b1;
        end else begin
          dist_sum = grown[SUM_WIDTH-1:0];
        end
        if (pair.final_pair) begin
          prod = 64'(decay_q12) * 64'(dist_sum);
          if (prod > 64'hFFFF_FFFF) begin
            prod = 64'hFFFF_FFFF;
          end
          // split into multiples of ln2 and a remainder that indexes the table
          k = prod / LN2_FIX20;
          r = prod - k * LN2_FIX20;
          if (k >= 16) begin
            want.kernel_value = '0;
          end else begin
            idx = (r * 64'(EXP_TABLE_DEPTH)) / LN2_FIX20;
            if (idx >= 64'(EXP_TABLE_DEPTH)) begin
              idx = 64'(EXP_TABLE_DEPTH) - 1;
            end
            entry = 64'(pow2_q15[idx[IDX_W-1:0]]);
            if (k != 0) begin
              entry = (entry + (64'd1 << (k - 1))) >> k;
            end
            want.kernel_value = VAL_W'(entry);
          end
          want.sum_saturated = dist_sat;
          kernel_due.push_back(want);
          dist_sum = '0;
          dist_sat = 1'b0;
        end
        words_taken++;
      end
    end
  end

  // watchdog on cycles with no word moving either way
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                           input logic last);
    lapk_in_t w;
    w.first_element  = a;
    w.second_element = b;
    w.final_pair     = last;
    pair_queue.push_back(w);
    words_queued++;
  endtask

  task automatic send_vector(input int unsigned len);
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic [ELEM_W-1:0] delta;
    int unsigned       spread;
    int unsigned       sel;
    for (int unsigned i = 0; i < len; i++) begin
      sel = $urandom_range(0, 7);
      if (sel < 2) begin
        a = ELEM_W'($urandom());
        b = ELEM_W'($urandom());
      end else if (sel == 2) begin
        case ($urandom_range(0, 3))
          0: a = 16'h8000;
          1: a = 16'h7FFF;
          2: a = 16'h0000;
          default: a = 16'hFFFF;
        endcase
        case ($urandom_range(0, 3))
          0: b = 16'h8000;
          1: b = 16'h7FFF;
          2: b = 16'h0000;
          default: b = 16'hFFFF;
        endcase
      end else begin
        // nearby elements keep the distance small, toward the range where exp is nonzero
        case ($urandom_range(0, 3))
          0: spread = 8;
          1: spread = 128;
          2: spread = 1024;
          default: spread = 8192;
        endcase
        a     = ELEM_W'($urandom());
        delta = ELEM_W'($urandom_range(0, 2 * spread) - spread);
        b     = a + delta;
      end
      push_pair(a, b, i == len - 1);
    end
  endtask

  task automatic send_random_vectors(input int unsigned words);
    int unsigned target;
    int unsigned sel;
    target = words_queued + words;
    while (words_queued < target) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        send_vector($urandom_range(1, 6));
      end else if (sel < 19) begin
        send_vector($urandom_range(7, 30));
      end else begin
        send_vector($urandom_range(31, 80));
      end
    end
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || kernel_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_decay(input logic [DECAY_W-1:0] rate);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    decay_q12    = rate;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] acc;
    // 2^(-i/depth) table in q1.15 from a truncating q.32 series
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      t    = (64'(i) * LN2_FIX32) / 64'(EXP_TABLE_DEPTH);
      term = 64'd1 << 32;
      acc  = 64'd1 << 32;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * t) >> 32) / 64'(n);
        acc  = n[0] ? acc - term : acc + term;
      end
      pow2_q15[IDX_W'(i)] = VAL_W'((acc + (64'd1 << 16)) >> 17);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset decay rate of 1.0
    push_pair(16'h0000, 16'h0000, 1'b1);
    push_pair(16'h7FFF, 16'h8000, 1'b1);
    push_pair(16'h8000, 16'h7FFF, 1'b1);
    push_pair(16'h0100, 16'h0000, 1'b1);
    push_pair(16'hFFFF, 16'hFFFF, 1'b0);
    push_pair(16'h0001, 16'hFFFF, 1'b1);
    push_pair(16'h7F00, 16'h7F00, 1'b1);
    push_pair(16'h0080, 16'hFF80, 1'b0);
    push_pair(16'h5555, 16'hAAAA, 1'b0);
    push_pair(16'h0000, 16'h0200, 1'b1);

    // zero decay rate always yields one
    set_decay(16'h0000);
    push_pair(16'h7FFF, 16'h8000, 1'b1);
    push_pair(16'h1234, 16'h1234, 1'b1);

    set_decay(16'hFFFF);
    push_pair(16'h0000, 16'h0001, 1'b1);
    push_pair(16'h8000, 16'h7FFF, 1'b1);
    push_pair(16'h0000, 16'h0000, 1'b1);

    // saturating sum that tips over only on the final pair
    set_decay(16'h0001);
    for (int i = 0; i < 1024; i++) begin
      push_pair(16'h7FFF, 16'h8000, 1'b0);
    end
    push_pair(16'h0000, 16'd2000, 1'b1);

    set_decay(DECAY_W'(4096));
    send_random_vectors(50);
    set_decay(DECAY_W'($urandom_range(1, 300)));
    send_random_vectors(30);
    set_decay(16'hFFFF);
    send_random_vectors(25);
    set_decay(DECAY_W'($urandom()));
    send_random_vectors(40);
    set_decay(16'h0000);
    send_random_vectors(15);
    set_decay(DECAY_W'($urandom_range(300, 4096)));
    send_random_vectors(40);

    // short vectors queued up while the receiver holds off
    set_decay(DECAY_W'($urandom_range(1, 8192)));
    for (int i = 0; i < 30; i++) begin
      send_vector($urandom_range(1, 2));
    end
    @(posedge clk_i);
    hold_req <= hold_req + 1;
    send_random_vectors(50);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && kernel_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lapk_pkg.sv
rtl/lapk_ctrl.sv
rtl/lapk_dp.sv
rtl/laplacian_kernel_l1_exp.sv
rtl/lapk_chk.sv
tb/tb.sv
